// ===== hdl/cfr_pkg.sv =====
`default_nettype none

package cfr_pkg;

  localparam int MAX_PAYLOAD_DEF = 4096;

  localparam logic [31:0] CRC_POLY   = 32'hedb88320;
  localparam logic [31:0] CRC_PRESET = 32'hffffffff;

  localparam logic [12:0] CAPACITY_RESET = 13'd4096;
  localparam logic [7:0]  VERSION_RESET  = 8'd1;
  localparam logic [23:0] TIMEOUT_RESET  = 24'd1000000;

  localparam int CFG_DATA_W = 24;

  // register indexes on the configuration port
  localparam logic [1:0] REG_CAPACITY = 2'd0;
  localparam logic [1:0] REG_VERSION  = 2'd1;
  localparam logic [1:0] REG_TIMEOUT  = 2'd2;
  localparam logic [1:0] REG_PREFIX   = 2'd3;

  typedef enum logic [1:0] {
    PH_HUNT    = 2'd0,
    PH_HEADER  = 2'd1,
    PH_PAYLOAD = 2'd2,
    PH_CRC     = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_VERSION = 3'd1,
    ST_LENGTH  = 3'd2,
    ST_CRC     = 3'd3,
    ST_TIMEOUT = 3'd4
  } status_t;

  typedef enum logic {
    KIND_PAYLOAD = 1'b0,
    KIND_END     = 1'b1
  } kind_t;

  typedef enum logic {
    REQ_BYTE = 1'b0,
    REQ_TICK = 1'b1
  } req_t;

  typedef struct packed {
    logic [12:0] capacity;
    logic [7:0]  version;
    logic [23:0] timeout;
    logic        prefix;
  } cfg_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  data;
    logic [7:0]  ftype;
    logic [15:0] flen;
    status_t     status;
  } result_t;

  function automatic logic [7:0] magic_byte(input logic [1:0] idx);
    logic [7:0] b;
    case (idx)
      2'd0:    b = 8'h43;  // C
      2'd1:    b = 8'h42;  // B
      2'd2:    b = 8'h50;  // P
      default: b = 8'h31;  // 1
    endcase
    return b;
  endfunction

  // reflected CRC-32, one byte
  function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] x;
    x = c ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      x = x[0] ? ((x >> 1) ^ CRC_POLY) : (x >> 1);
    end
    return x;
  endfunction

  localparam logic [31:0] CRC_MAGIC =
    crc_byte(crc_byte(crc_byte(crc_byte(CRC_PRESET, 8'h43), 8'h42), 8'h50), 8'h31);

endpackage

`default_nettype wire

// ===== hdl/cfr_deframer.sv =====
`default_nettype none

module cfr_deframer #(
  parameter int MAX_PAYLOAD = cfr_pkg::MAX_PAYLOAD_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            step,
  input  wire cfr_pkg::req_t   req_type,
  input  wire logic [7:0]      in_byte,
  input  wire cfr_pkg::cfg_t   cfg,
  output logic                 res_valid,
  output cfr_pkg::result_t     res
);

  localparam logic [15:0] MaxLen = 16'(MAX_PAYLOAD);

  cfr_pkg::phase_t phase_r, phase_nxt;
  logic [1:0]  magic_r, magic_nxt;
  logic [15:0] count_r, count_nxt;
  logic [7:0]  htype_r, htype_nxt;
  logic [15:0] hlen_r, hlen_nxt;
  logic [31:0] crc_r, crc_nxt;
  logic [31:0] rcrc_r, rcrc_nxt;
  logic [23:0] timer_r, timer_nxt;
  logic        first_r, first_nxt;

  logic        prefix_applies;
  logic        timed;
  logic [23:0] timer_inc;
  logic [1:0]  m_start;
  logic [2:0]  m_new;
  logic [31:0] crc_upd;
  logic [15:0] count_inc;
  logic [15:0] len_full;
  logic [31:0] rcrc_shift;
  logic        finish;
  cfr_pkg::status_t fin_status;

  always_comb begin
    prefix_applies = first_r && cfg.prefix;
    timed     = (phase_r != cfr_pkg::PH_HUNT) || (magic_r != 2'd0) || prefix_applies;
    timer_inc = (timer_r != 24'hffffff) ? timer_r + 24'd1 : timer_r;
    m_start   = (prefix_applies && count_r == 16'd0) ? 2'd1 : magic_r;
    if (in_byte == cfr_pkg::magic_byte(m_start)) begin
      m_new = {1'b0, m_start} + 3'd1;
    end else begin
      m_new = (in_byte == cfr_pkg::magic_byte(2'd0)) ? 3'd1 : 3'd0;
    end
    crc_upd    = cfr_pkg::crc_byte(crc_r, in_byte);
    count_inc  = count_r + 16'd1;
    len_full   = {hlen_r[15:8], in_byte};
    rcrc_shift = {rcrc_r[23:0], in_byte};

    phase_nxt  = phase_r;
    magic_nxt  = magic_r;
    count_nxt  = count_r;
    htype_nxt  = htype_r;
    hlen_nxt   = hlen_r;
    crc_nxt    = crc_r;
    rcrc_nxt   = rcrc_r;
    timer_nxt  = timer_r;
    first_nxt  = first_r;
    finish     = 1'b0;
    fin_status = cfr_pkg::ST_OK;
    res_valid  = 1'b0;
    res.kind   = cfr_pkg::KIND_PAYLOAD;
    res.data   = in_byte;
    res.status = cfr_pkg::ST_OK;

    if (req_type == cfr_pkg::REQ_TICK) begin
      if (timed) begin
        timer_nxt = timer_inc;
        if (timer_inc >= cfg.timeout) begin
          finish     = 1'b1;
          fin_status = cfr_pkg::ST_TIMEOUT;
        end
      end
    end else begin
      timer_nxt = 24'd0;
      case (phase_r)
        cfr_pkg::PH_HUNT: begin
          count_nxt = 16'd1;
          if (m_new[2]) begin
            phase_nxt = cfr_pkg::PH_HEADER;
            magic_nxt = 2'd0;
            count_nxt = 16'd0;
            htype_nxt = 8'd0;
            hlen_nxt  = 16'd0;
            rcrc_nxt  = 32'd0;
            crc_nxt   = cfr_pkg::CRC_MAGIC;
          end else begin
            magic_nxt = m_new[1:0];
          end
        end
        cfr_pkg::PH_HEADER: begin
          crc_nxt   = crc_upd;
          count_nxt = count_inc;
          case (count_r)
            16'd0: rcrc_nxt = {24'd0, in_byte};  // hold version until header is complete
            16'd1: htype_nxt = in_byte;
            16'd2: hlen_nxt = {in_byte, 8'd0};
            default: begin
              hlen_nxt = len_full;
              if (rcrc_r != {24'd0, cfg.version}) begin
                finish     = 1'b1;
                fin_status = cfr_pkg::ST_VERSION;
              end else if (len_full > {3'd0, cfg.capacity} || len_full > MaxLen) begin
                finish     = 1'b1;
                fin_status = cfr_pkg::ST_LENGTH;
              end else begin
                rcrc_nxt  = 32'd0;
                count_nxt = 16'd0;
                phase_nxt = (len_full == 16'd0) ? cfr_pkg::PH_CRC : cfr_pkg::PH_PAYLOAD;
              end
            end
          endcase
        end
        cfr_pkg::PH_PAYLOAD: begin
          crc_nxt   = crc_upd;
          res_valid = 1'b1;
          count_nxt = count_inc;
          if (count_inc >= hlen_r) begin
            count_nxt = 16'd0;
            phase_nxt = cfr_pkg::PH_CRC;
          end
        end
        default: begin
          rcrc_nxt  = rcrc_shift;
          count_nxt = count_inc;
          if (count_inc >= 16'd4) begin
            finish     = 1'b1;
            fin_status = (rcrc_shift == ~crc_r) ? cfr_pkg::ST_OK : cfr_pkg::ST_CRC;
          end
        end
      endcase
    end

    if (finish) begin
      res_valid  = 1'b1;
      res.kind   = cfr_pkg::KIND_END;
      res.data   = 8'd0;
      res.status = fin_status;
      phase_nxt  = cfr_pkg::PH_HUNT;
      magic_nxt  = 2'd0;
      count_nxt  = 16'd0;
      crc_nxt    = cfr_pkg::CRC_PRESET;
      rcrc_nxt   = 32'd0;
      timer_nxt  = 24'd0;
      first_nxt  = 1'b0;
    end
    res.ftype = htype_nxt;
    res.flen  = hlen_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= cfr_pkg::PH_HUNT;
      magic_r <= 2'd0;
      count_r <= 16'd0;
      htype_r <= 8'd0;
      hlen_r  <= 16'd0;
      crc_r   <= cfr_pkg::CRC_PRESET;
      rcrc_r  <= 32'd0;
      timer_r <= 24'd0;
      first_r <= 1'b1;
    end else if (step) begin
      phase_r <= phase_nxt;
      magic_r <= magic_nxt;
      count_r <= count_nxt;
      htype_r <= htype_nxt;
      hlen_r  <= hlen_nxt;
      crc_r   <= crc_nxt;
      rcrc_r  <= rcrc_nxt;
      timer_r <= timer_nxt;
      first_r <= first_nxt;
    end
  end

`ifndef SYNTHESIS
  a_magic_only_in_hunt: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r != cfr_pkg::PH_HUNT) |-> (magic_r == 2'd0))
    else $error("magic match count left over outside hunt");

  a_header_count: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == cfr_pkg::PH_HEADER) |-> (count_r < 16'd4))
    else $error("header byte count out of range");

  a_payload_count: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == cfr_pkg::PH_PAYLOAD) |-> (count_r < hlen_r))
    else $error("payload count reached frame length");

  a_end_to_hunt: assert property (@(posedge clk) disable iff (!rst_n)
    (step && res_valid && res.kind == cfr_pkg::KIND_END)
      |=> (phase_r == cfr_pkg::PH_HUNT && !first_r && timer_r == 24'd0))
    else $error("frame end did not return to hunt");
`endif

endmodule

`default_nettype wire

// ===== hdl/cfr_out_stage.sv =====
`default_nettype none

module cfr_out_stage (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              load,
  input  wire cfr_pkg::result_t  res,
  output logic                   can_load,
  input  wire logic              out_tready,
  output logic                   out_tvalid,
  output cfr_pkg::result_t       out_res
);

  logic             valid_r;
  cfr_pkg::result_t res_r;

  assign can_load   = !valid_r || out_tready;
  assign out_tvalid = valid_r;
  assign out_res    = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (can_load) begin
      valid_r <= load;
    end
  end

  // payload needs no reset; hold while the transaction is stalled
  always_ff @(posedge clk) begin
    if (can_load && load) begin
      res_r <= res;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/crc32_frame_receiver.sv =====
`default_nettype none

// Frame receiver for a byte stream framed by the magic "CBP1", a version byte, a type
// byte, a big-endian 16-bit payload length, the payload and a big-endian reflected
// CRC-32 over magic, header and payload. Each input transaction is a received byte
// (in_tuser = 0) or one time tick (in_tuser = 1). Every payload byte is forwarded at
// once as out_tuser = 0; one frame-end transaction (out_tuser = 1) carries the status
// (ok, version mismatch, length error, CRC mismatch, inter-byte timeout), after which
// the receiver hunts for the magic again. Discard the payload unless the status is ok.
// One transaction is taken every clock cycle unless the output stalls; a result
// passes through the input register, the combinational header/CRC update and the
// output register. Configuration writes take effect at once and are not ordered
// against held transactions, so write them only while no transaction is in flight.
module crc32_frame_receiver #(
  parameter int MAX_PAYLOAD = cfr_pkg::MAX_PAYLOAD_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] in_byte
  input  wire logic        in_tuser,   // [0] req_type
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata,  // [7:0] out_byte, [15:8] frame_type,
                                       // [31:16] frame_length, [34:32] status
  output logic             out_tuser,  // [0] out_kind
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [cfr_pkg::CFG_DATA_W-1:0] cfg_data
);

  cfr_pkg::cfg_t    cfg_r;
  logic             in_valid_r;
  cfr_pkg::req_t    in_type_r;
  logic [7:0]       in_byte_r;
  logic             advance;
  logic             can_load;
  logic             res_valid;
  cfr_pkg::result_t res;
  cfr_pkg::result_t out_res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.capacity <= cfr_pkg::CAPACITY_RESET;
      cfg_r.version  <= cfr_pkg::VERSION_RESET;
      cfg_r.timeout  <= cfr_pkg::TIMEOUT_RESET;
      cfg_r.prefix   <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        cfr_pkg::REG_CAPACITY: cfg_r.capacity <= cfg_data[12:0];
        cfr_pkg::REG_VERSION:  cfg_r.version  <= cfg_data[7:0];
        cfr_pkg::REG_TIMEOUT:  cfg_r.timeout  <= cfg_data[23:0];
        cfr_pkg::REG_PREFIX:   cfg_r.prefix   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // advance the held item whenever the output register can take its result
  assign advance   = in_valid_r && can_load;
  assign in_tready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_type_r <= cfr_pkg::req_t'(in_tuser);
      in_byte_r <= in_tdata;
    end
  end

  cfr_deframer #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_deframer (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (advance),
    .req_type  (in_type_r),
    .in_byte   (in_byte_r),
    .cfg       (cfg_r),
    .res_valid (res_valid),
    .res       (res)
  );

  cfr_out_stage u_out_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (advance && res_valid),
    .res        (res),
    .can_load   (can_load),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_res    (out_res)
  );

  assign out_tuser = out_res.kind;
  assign out_tdata = {5'd0, out_res.status, out_res.flen, out_res.ftype, out_res.data};

`ifndef SYNTHESIS
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !in_valid_r |-> in_tready)
    else $error("input register empty but not ready");

  a_no_step_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |-> !advance)
    else $error("item advanced into a stalled output register");

  a_held_item_advances: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && !out_tvalid) |-> advance)
    else $error("held item not processed with free output register");
`endif

endmodule

`default_nettype wire
